// File: src/rgbc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rgbc_pkg: shared types and constants for the RGB interpolated curve LUT
// Field widths, command codes and the task word passed from front to back.
// ----------------------------------------------------------------------------
package rgbc_pkg;

    localparam int MAX_NODES_DEF = 64;
    localparam int NUM_CH        = 3;
    localparam int CODE_W        = 8;
    localparam int NODE_W        = 16;
    localparam int IDX_W         = 8;
    localparam int CNT_W         = 9;
    localparam int CH_W          = 2;
    localparam int NUM_W         = CODE_W + NODE_W;
    localparam int QUEUE_DEPTH   = 4;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    localparam logic [CH_W-1:0]   CH_LAST    = 2'd2;
    localparam logic [CODE_W-1:0] CODE_MAX   = 8'd255;
    localparam logic [NODE_W-1:0] NODE_MAX   = 16'hFFFF;
    localparam logic [NODE_W-1:0] ROUND_HALF = 16'h7FFF;

    typedef enum logic {
        KIND_WRITE,
        KIND_PIXEL
    } t_kind;

    typedef struct packed {
        t_kind                          kind;
        logic [CH_W-1:0]                chan;
        logic [IDX_W-1:0]               wr_idx;
        logic [NODE_W-1:0]              wr_value;
        logic [NUM_CH-1:0][IDX_W-1:0]   idx0;
        logic [NUM_CH-1:0][IDX_W-1:0]   idx1;
        logic [NUM_CH-1:0][CODE_W-1:0]  frac;
    } t_task;

    typedef struct packed {
        logic clearing;
    } t_back_status;

endpackage
`default_nettype wire

// File: src/rgbc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rgbc_front: input acceptance and classification
// Holds the clamped node count, drops writes that fall outside the store,
// and turns each pixel code into a node pair and an interpolation fraction.
// ----------------------------------------------------------------------------
module rgbc_front #(
    parameter int MAX_NODES = rgbc_pkg::MAX_NODES_DEF
) (
    input  wire logic                                          i_clk,
    input  wire logic                                          i_rst_n,
    input  wire logic                                          i_cfg_we,
    input  wire logic [rgbc_pkg::CNT_W-1:0]                    i_cfg_wdata,
    input  wire logic                                          i_valid,
    output logic                                               o_stall,
    input  wire logic                                          i_command,
    input  wire logic [rgbc_pkg::CH_W-1:0]                     i_channel,
    input  wire logic [rgbc_pkg::IDX_W-1:0]                    i_node_index,
    input  wire logic [rgbc_pkg::NODE_W-1:0]                   i_node_value,
    input  wire logic [rgbc_pkg::NUM_CH-1:0][rgbc_pkg::CODE_W-1:0] i_code,
    input  wire rgbc_pkg::t_back_status                        i_status,
    input  wire logic                                          i_can_push,
    output logic                                               o_push,
    output rgbc_pkg::t_task                                    o_task
);
    import rgbc_pkg::*;

    localparam int PROD_W = CODE_W + IDX_W;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_NODES);

    logic [IDX_W-1:0] r_nm1;
    logic [IDX_W-1:0] n_nm1;

    logic              r_f_valid;
    logic              n_f_valid;
    t_kind             r_f_kind;
    logic [CH_W-1:0]   r_f_chan;
    logic [IDX_W-1:0]  r_f_idx;
    logic [NODE_W-1:0] r_f_value;
    logic [NUM_CH-1:0][PROD_W-1:0] r_f_prod;

    logic accept;
    logic drop;
    logic advance;

    // node count in use, minus one, clamped on the way in
    always_comb begin
        if (i_cfg_wdata < CNT_W'(2)) begin
            n_nm1 = IDX_W'(1);
        end else if (i_cfg_wdata > MAX_CNT) begin
            n_nm1 = IDX_W'(MAX_NODES - 1);
        end else begin
            n_nm1 = IDX_W'(i_cfg_wdata - CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nm1 <= IDX_W'(1);
        end else if (i_cfg_we) begin
            r_nm1 <= n_nm1;
        end
    end

    assign advance = r_f_valid && i_can_push;
    assign o_stall = i_status.clearing || (r_f_valid && !i_can_push);
    assign accept  = i_valid && !o_stall;
    assign drop    = (i_command == CMD_WRITE) &&
                     ((i_channel > CH_LAST) || ({1'b0, i_node_index} >= MAX_CNT));

    always_comb begin
        if (accept) begin
            n_f_valid = !drop;
        end else if (advance) begin
            n_f_valid = 1'b0;
        end else begin
            n_f_valid = r_f_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else begin
            r_f_valid <= n_f_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_f_kind  <= (i_command == CMD_PIXEL) ? KIND_PIXEL : KIND_WRITE;
            r_f_chan  <= i_channel;
            r_f_idx   <= i_node_index;
            r_f_value <= i_node_value;
            for (int c = 0; c < NUM_CH; c++) begin
                r_f_prod[c] <= PROD_W'(i_code[c]) * PROD_W'(r_nm1);
            end
        end
    end

    // divide by 255: the quotient estimate p/256 is low by at most one
    always_comb begin
        logic [IDX_W-1:0] q;
        logic [IDX_W:0]   rem;
        logic [IDX_W-1:0] idx0;

        o_task          = '0;
        o_task.kind     = r_f_kind;
        o_task.chan     = r_f_chan;
        o_task.wr_idx   = r_f_idx;
        o_task.wr_value = r_f_value;
        for (int c = 0; c < NUM_CH; c++) begin
            q   = r_f_prod[c][PROD_W-1:CODE_W];
            rem = {1'b0, r_f_prod[c][CODE_W-1:0]} + {1'b0, q};
            if (rem >= {1'b0, CODE_MAX}) begin
                idx0           = q + IDX_W'(1);
                o_task.frac[c] = CODE_W'(rem - {1'b0, CODE_MAX});
            end else begin
                idx0           = q;
                o_task.frac[c] = rem[CODE_W-1:0];
            end
            o_task.idx0[c] = idx0;
            o_task.idx1[c] = (idx0 == r_nm1) ? idx0 : idx0 + IDX_W'(1);
        end
    end

    assign o_push = advance;

endmodule
`default_nettype wire

// File: src/rgbc_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rgbc_queue: short task queue between front and back
// Lets the front keep accepting while the back waits on its output.
// ----------------------------------------------------------------------------
module rgbc_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire rgbc_pkg::t_task i_task,
    output logic                 o_can_push,
    output logic                 o_valid,
    input  wire logic            i_pop,
    output rgbc_pkg::t_task      o_task
);
    import rgbc_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_task            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_count;

    assign o_can_push = (r_count != (PTR_W + 1)'(QUEUE_DEPTH));
    assign o_valid    = (r_count != '0);
    assign o_task     = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_task;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (PTR_W + 1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (PTR_W + 1)'(1);
            end
        end
    end

endmodule
`default_nettype wire

// File: src/rgbc_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rgbc_back: node store and interpolation pipeline
// Writes nodes, reads node pairs, blends them and rounds to 8-bit codes.
// Clears the node store one row per cycle after reset.
// ----------------------------------------------------------------------------
module rgbc_back #(
    parameter int MAX_NODES = rgbc_pkg::MAX_NODES_DEF
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_rst_n,
    input  wire logic                                      i_valid,
    input  wire rgbc_pkg::t_task                           i_task,
    output logic                                           o_pop,
    output rgbc_pkg::t_back_status                         o_status,
    output logic                                           o_valid,
    input  wire logic                                      i_stall,
    output logic [rgbc_pkg::NUM_CH-1:0][rgbc_pkg::CODE_W-1:0] o_code
);
    import rgbc_pkg::*;

    localparam int AW = $clog2(MAX_NODES);

    logic          r_clearing;
    logic [AW-1:0] r_clr_addr;

    logic en;
    logic pop;

    logic                          r_s1_valid;
    logic [NUM_CH-1:0][CODE_W-1:0] r_s1_frac;
    logic [NUM_CH-1:0][NODE_W-1:0] r_v0;
    logic [NUM_CH-1:0][NODE_W-1:0] r_v1;

    logic                          r_s2_valid;
    logic [NUM_CH-1:0][NUM_W-1:0]  r_p0;
    logic [NUM_CH-1:0][NUM_W-1:0]  r_p1;

    logic                          r_s3_valid;
    logic [NUM_CH-1:0][NUM_W-1:0]  r_m;

    logic                          r_out_valid;
    logic [NUM_CH-1:0][CODE_W-1:0] r_out;
    logic [NUM_CH-1:0][CODE_W-1:0] n_out;

    // whole pipeline moves together; the queue absorbs the stall
    assign en    = !r_out_valid || !i_stall;
    assign pop   = en && i_valid && !r_clearing;
    assign o_pop = pop;

    assign o_status.clearing = r_clearing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == AW'(MAX_NODES - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
        logic [NODE_W-1:0] r_mem [MAX_NODES];

        always_ff @(posedge i_clk) begin
            if (r_clearing) begin
                r_mem[r_clr_addr] <= '0;
            end else if (pop && (i_task.kind == KIND_WRITE) &&
                         (i_task.chan == CH_W'(c))) begin
                r_mem[i_task.wr_idx[AW-1:0]] <= i_task.wr_value;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_v0[c] <= r_mem[i_task.idx0[c][AW-1:0]];
                r_v1[c] <= r_mem[i_task.idx1[c][AW-1:0]];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid  <= pop && (i_task.kind == KIND_PIXEL);
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_out_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_frac <= i_task.frac;
            for (int c = 0; c < NUM_CH; c++) begin
                r_p0[c] <= NUM_W'(CODE_MAX - r_s1_frac[c]) * NUM_W'(r_v0[c]);
                r_p1[c] <= NUM_W'(r_s1_frac[c]) * NUM_W'(r_v1[c]);
                r_m[c]  <= r_p0[c] + r_p1[c] + NUM_W'(ROUND_HALF);
            end
            r_out <= n_out;
        end
    end

    // divide by 65535: the estimate m/65536 is low by at most one
    always_comb begin
        logic [CODE_W-1:0] q;
        logic [NODE_W:0]   rem;

        for (int c = 0; c < NUM_CH; c++) begin
            q   = r_m[c][NUM_W-1:NODE_W];
            rem = {1'b0, r_m[c][NODE_W-1:0]} + (NODE_W + 1)'(q);
            if ((rem >= {1'b0, NODE_MAX}) && (q != CODE_MAX)) begin
                n_out[c] = q + CODE_W'(1);
            end else begin
                n_out[c] = q;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_code  = r_out;

endmodule
`default_nettype wire

// File: src/rgb_interpolated_curve_lut.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_interpolated_curve_lut: per-channel piecewise-linear tone curve
// Maps 8-bit RGB pixels through three curves of up to MAX_NODES 16-bit nodes.
// ----------------------------------------------------------------------------
// Takes one word per clock while o_stall is low, node write or pixel, and
// returns one mapped pixel per pixel word; node writes give no result. The
// rate is one word per cycle, set by the dual-read node store of each channel
// being read once per pixel. A four-entry queue sits between the classifying
// front and the interpolation back, so the input keeps flowing for a few
// words while the output is stalled. After reset the node store is cleared
// row by row, during which o_stall is high; configuration writes are taken
// as ever. node_count is clamped to the range 2..MAX_NODES.
// ----------------------------------------------------------------------------
module rgb_interpolated_curve_lut #(
    parameter int MAX_NODES = rgbc_pkg::MAX_NODES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [rgbc_pkg::CNT_W-1:0]    i_cfg_wdata,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic                          i_command,
    input  wire logic [rgbc_pkg::CH_W-1:0]     i_channel,
    input  wire logic [rgbc_pkg::IDX_W-1:0]    i_node_index,
    input  wire logic [rgbc_pkg::NODE_W-1:0]   i_node_value,
    input  wire logic [rgbc_pkg::CODE_W-1:0]   i_red_in,
    input  wire logic [rgbc_pkg::CODE_W-1:0]   i_green_in,
    input  wire logic [rgbc_pkg::CODE_W-1:0]   i_blue_in,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [rgbc_pkg::CODE_W-1:0]        o_red_out,
    output logic [rgbc_pkg::CODE_W-1:0]        o_green_out,
    output logic [rgbc_pkg::CODE_W-1:0]        o_blue_out
);
    import rgbc_pkg::*;

    logic [NUM_CH-1:0][CODE_W-1:0] code_in;
    logic [NUM_CH-1:0][CODE_W-1:0] code_out;

    t_back_status status;
    t_task        push_task;
    t_task        pop_task;
    logic         push;
    logic         can_push;
    logic         pop;
    logic         task_valid;

    assign code_in = {i_blue_in, i_green_in, i_red_in};

    rgbc_front #(
        .MAX_NODES (MAX_NODES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_command    (i_command),
        .i_channel    (i_channel),
        .i_node_index (i_node_index),
        .i_node_value (i_node_value),
        .i_code       (code_in),
        .i_status     (status),
        .i_can_push   (can_push),
        .o_push       (push),
        .o_task       (push_task)
    );

    rgbc_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_task     (push_task),
        .o_can_push (can_push),
        .o_valid    (task_valid),
        .i_pop      (pop),
        .o_task     (pop_task)
    );

    rgbc_back #(
        .MAX_NODES (MAX_NODES)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (task_valid),
        .i_task   (pop_task),
        .o_pop    (pop),
        .o_status (status),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_code   (code_out)
    );

    assign o_red_out   = code_out[0];
    assign o_green_out = code_out[1];
    assign o_blue_out  = code_out[2];

endmodule
`default_nettype wire
